// ----- rtl/asrm_pkg.sv -----
// ----------------------------------------------------------------------------
// asrm_pkg
// shared types and constants of the advert spam rate monitor: beat layouts,
// command codes, register indexes, structure types and vendor identifiers
// ----------------------------------------------------------------------------
package asrm_pkg;

    typedef enum logic [2:0] {
        CMD_BYTE    = 3'd0,
        CMD_TICK    = 3'd1,
        CMD_RESTART = 3'd2,
        CMD_PAUSE   = 3'd3,
        CMD_RESUME  = 3'd4,
        CMD_READ    = 3'd5
    } cmd_t;

    localparam logic [1:0] REG_ALERT_THRESHOLD  = 2'd0;
    localparam logic [1:0] REG_SECOND_LENGTH_MS = 2'd1;
    localparam logic [1:0] REG_ALERT_HOLD_MS    = 2'd2;

    localparam logic [15:0] ALERT_THRESHOLD_RESET  = 16'd20;
    localparam logic [15:0] SECOND_LENGTH_MS_RESET = 16'd1000;
    localparam logic [15:0] ALERT_HOLD_MS_RESET    = 16'd4000;

    localparam logic [7:0]  TYPE_MAKER   = 8'hFF;
    localparam logic [7:0]  TYPE_SERVICE = 8'h16;
    localparam logic [15:0] CID_004C     = 16'h004C;
    localparam logic [15:0] CID_0006     = 16'h0006;
    localparam logic [15:0] CID_0075     = 16'h0075;
    localparam logic [15:0] UUID_FE2C    = 16'hFE2C;

    localparam int SLOT_004C = 0;
    localparam int SLOT_0006 = 1;
    localparam int SLOT_0075 = 2;
    localparam int SLOT_FE2C = 3;
    localparam int VENDORS   = 4;

    localparam int MS_PER_SECOND = 1000;

    // offset into structure data saturates at three, only 0..2 matter
    localparam logic [1:0] OFFSET_TYPE = 2'd0;
    localparam logic [1:0] OFFSET_LOW  = 2'd1;
    localparam logic [1:0] OFFSET_HIGH = 2'd2;
    localparam logic [1:0] OFFSET_REST = 2'd3;

    typedef struct packed {
        logic [7:0]  bytes_left;
        logic [7:0]  stype;
        logic [1:0]  offset;
        logic        ended;
        logic        maker_found;
        logic [15:0] maker_id;
        logic        service_found;
        logic [15:0] service_uuid;
    } walk_t;

    typedef struct packed {
        logic [2:0] cmd;
        logic [7:0] data_byte;
        logic       last_byte;
        logic [5:0] history_index;
    } in_t;

    typedef struct packed {
        logic [15:0] rate;
        logic [31:0] total;
        logic [15:0] peak;
        logic [15:0] count_cid_004c;
        logic [15:0] count_cid_0006;
        logic [15:0] count_cid_0075;
        logic [15:0] count_uuid_fe2c;
        logic        alert;
        logic [31:0] uptime_seconds;
        logic [15:0] history_value;
        logic        advert_was_spam;
    } out_t;

endpackage

// ----- rtl/asrm_ram.sv -----
// ----------------------------------------------------------------------------
// asrm_ram
// generic single-clock ram, one write port and one read port, read data
// registered and held while the read enable is low
// ----------------------------------------------------------------------------
module asrm_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- rtl/adv_spam_rate_monitor.sv -----
// ----------------------------------------------------------------------------
// adv_spam_rate_monitor
// walks advert payload bytes, classifies spam adverts by vendor and keeps
// per-interval rates, peak, snapshots, alert hold, uptime and a rate history
// ----------------------------------------------------------------------------
// One beat is taken every clock cycle while in_stall is low, and every
// beat gives one result beat, through the registered read of the history
// ram and then a two-entry output queue that keeps taking beats while a
// result waits. All walk and counter state updates in the accept cycle.
// The history ring sits in one ram written at interval close; a fill count
// makes entries never written since restart read as zero, so there is no
// clearing pass after reset or restart.
module adv_spam_rate_monitor #(
    parameter int HISTORY_DEPTH = 64,
    parameter int ADV_BYTES     = 31
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_stall,
    input  asrm_pkg::in_t   in_data,
    output logic            out_valid,
    input  logic            out_stall,
    output asrm_pkg::out_t  out_data,
    input  logic            cfg_write,
    input  logic [1:0]      cfg_index,
    input  logic [15:0]     cfg_data
);

    localparam int HIST_AW = $clog2(HISTORY_DEPTH);
    localparam int FILL_W  = $clog2(HISTORY_DEPTH + 1);
    localparam int POS_W   = $clog2(ADV_BYTES + 1);
    localparam int SUM_W   = ((HIST_AW > 6) ? HIST_AW : 6) + 1;

    // configuration
    logic [15:0] threshold_reg;
    logic [15:0] second_len_reg;
    logic [15:0] hold_reg;

    // monitor state
    logic [POS_W-1:0]   pos_reg, pos_next;
    asrm_pkg::walk_t    walk_reg, walk_next, walk_step;
    logic [POS_W-1:0]   pos_step;
    logic [15:0]        count_reg, count_next;
    logic [31:0]        spam_total_reg, spam_total_next;
    logic [15:0]        vendor_live_reg [asrm_pkg::VENDORS];
    logic [15:0]        vendor_live_next [asrm_pkg::VENDORS];
    logic [15:0]        vendor_snap_reg [asrm_pkg::VENDORS];
    logic [15:0]        vendor_snap_next [asrm_pkg::VENDORS];
    logic [31:0]        total_snap_reg, total_snap_next;
    logic [15:0]        last_rate_reg, last_rate_next;
    logic [15:0]        peak_reg, peak_next;
    logic [HIST_AW-1:0] slot_reg, slot_next;
    logic [FILL_W-1:0]  fill_reg, fill_next;
    logic [15:0]        phase_reg, phase_next;
    logic [15:0]        alert_left_reg, alert_left_next;
    logic [9:0]         ms_reg, ms_next;
    logic [31:0]        secs_reg, secs_next;
    logic               running_reg, running_next;

    // read stage
    logic b_valid_reg;
    logic b_spam_reg, b_spam_next;
    logic b_hist_ok_reg, b_hist_ok_next;

    // output queue
    asrm_pkg::out_t fifo_reg [2];
    logic           fifo_wr_reg;
    logic           fifo_rd_reg;
    logic [1:0]     fifo_count_reg;
    asrm_pkg::out_t push_beat;
    logic           push;
    logic           pop;
    logic [2:0]     occupancy;

    // history ram
    logic               ram_we;
    logic               ram_re;
    logic [HIST_AW-1:0] ram_raddr;
    logic [15:0]        ram_rdata;
    logic [SUM_W-1:0]   hist_sum;
    logic               idx_ok;
    logic               entry_valid;

    logic           accept;
    asrm_pkg::cmd_t cmd;
    logic           hit_004c, hit_0006, hit_0075, hit_fe2c, spam;
    logic [15:0]    phase_inc;

    assign accept = in_valid && !in_stall;
    assign cmd    = asrm_pkg::cmd_t'(in_data.cmd);

    asrm_ram #(
        .WIDTH (16),
        .DEPTH (HISTORY_DEPTH)
    ) u_history (
        .clk   (clk),
        .we    (ram_we),
        .waddr (slot_reg),
        .wdata (count_reg),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // history address, oldest entry first
    always_comb
    begin
        idx_ok   = 32'(in_data.history_index) < HISTORY_DEPTH;
        hist_sum = SUM_W'(slot_reg) + SUM_W'(in_data.history_index);
        if (hist_sum >= SUM_W'(HISTORY_DEPTH))
        begin
            hist_sum = hist_sum - SUM_W'(HISTORY_DEPTH);
        end
        ram_raddr   = hist_sum[HIST_AW-1:0];
        entry_valid = (fill_reg == FILL_W'(HISTORY_DEPTH)) || (ram_raddr < slot_reg);
    end

    // structure walk for one payload byte
    always_comb
    begin
        walk_step = walk_reg;
        pos_step  = pos_reg;
        if (!walk_reg.ended && (pos_reg < POS_W'(ADV_BYTES)))
        begin
            pos_step = pos_reg + POS_W'(1);
            if (walk_reg.bytes_left == 8'd0)
            begin
                if (in_data.data_byte == 8'd0)
                begin
                    walk_step.ended = 1'b1;
                end
                else
                begin
                    walk_step.bytes_left = in_data.data_byte;
                    walk_step.offset     = asrm_pkg::OFFSET_TYPE;
                end
            end
            else
            begin
                case (walk_reg.offset)
                    asrm_pkg::OFFSET_TYPE:
                    begin
                        walk_step.stype = in_data.data_byte;
                    end
                    asrm_pkg::OFFSET_LOW:
                    begin
                        if (walk_reg.stype == asrm_pkg::TYPE_MAKER && !walk_reg.maker_found)
                        begin
                            walk_step.maker_id = {8'h00, in_data.data_byte};
                        end
                        if (walk_reg.stype == asrm_pkg::TYPE_SERVICE &&
                            !walk_reg.service_found)
                        begin
                            walk_step.service_uuid = {8'h00, in_data.data_byte};
                        end
                    end
                    asrm_pkg::OFFSET_HIGH:
                    begin
                        if (walk_reg.stype == asrm_pkg::TYPE_MAKER && !walk_reg.maker_found)
                        begin
                            walk_step.maker_id    = {in_data.data_byte, walk_reg.maker_id[7:0]};
                            walk_step.maker_found = 1'b1;
                        end
                        if (walk_reg.stype == asrm_pkg::TYPE_SERVICE &&
                            !walk_reg.service_found)
                        begin
                            walk_step.service_uuid  = {in_data.data_byte,
                                                       walk_reg.service_uuid[7:0]};
                            walk_step.service_found = 1'b1;
                        end
                    end
                    default:
                    begin
                    end
                endcase
                if (walk_reg.offset != asrm_pkg::OFFSET_REST)
                begin
                    walk_step.offset = walk_reg.offset + 2'd1;
                end
                walk_step.bytes_left = walk_reg.bytes_left - 8'd1;
            end
            if (pos_step >= POS_W'(ADV_BYTES))
            begin
                walk_step.ended = 1'b1;
            end
        end
    end

    // classification
    always_comb
    begin
        hit_004c = walk_step.maker_found && walk_step.maker_id == asrm_pkg::CID_004C;
        hit_0006 = walk_step.maker_found && walk_step.maker_id == asrm_pkg::CID_0006;
        hit_0075 = walk_step.maker_found && walk_step.maker_id == asrm_pkg::CID_0075;
        hit_fe2c = walk_step.service_found && walk_step.service_uuid == asrm_pkg::UUID_FE2C;
        spam     = hit_004c || hit_0006 || hit_0075 || hit_fe2c;
    end

    assign phase_inc = phase_reg + 16'd1;

    // command decode and state update
    always_comb
    begin
        pos_next        = pos_reg;
        walk_next       = walk_reg;
        count_next      = count_reg;
        spam_total_next = spam_total_reg;
        vendor_live_next = vendor_live_reg;
        vendor_snap_next = vendor_snap_reg;
        total_snap_next = total_snap_reg;
        last_rate_next  = last_rate_reg;
        peak_next       = peak_reg;
        slot_next       = slot_reg;
        fill_next       = fill_reg;
        phase_next      = phase_reg;
        alert_left_next = alert_left_reg;
        ms_next         = ms_reg;
        secs_next       = secs_reg;
        running_next    = running_reg;
        ram_we          = 1'b0;
        ram_re          = 1'b0;
        b_spam_next     = 1'b0;
        b_hist_ok_next  = 1'b0;
        if (accept)
        begin
            case (cmd)
                asrm_pkg::CMD_BYTE:
                begin
                    if (running_reg)
                    begin
                        pos_next  = pos_step;
                        walk_next = walk_step;
                        if (in_data.last_byte)
                        begin
                            if (hit_004c)
                            begin
                                vendor_live_next[asrm_pkg::SLOT_004C] =
                                    vendor_live_reg[asrm_pkg::SLOT_004C] + 16'd1;
                            end
                            if (hit_0006)
                            begin
                                vendor_live_next[asrm_pkg::SLOT_0006] =
                                    vendor_live_reg[asrm_pkg::SLOT_0006] + 16'd1;
                            end
                            if (hit_0075)
                            begin
                                vendor_live_next[asrm_pkg::SLOT_0075] =
                                    vendor_live_reg[asrm_pkg::SLOT_0075] + 16'd1;
                            end
                            if (hit_fe2c)
                            begin
                                vendor_live_next[asrm_pkg::SLOT_FE2C] =
                                    vendor_live_reg[asrm_pkg::SLOT_FE2C] + 16'd1;
                            end
                            if (spam)
                            begin
                                if (count_reg != 16'hFFFF)
                                begin
                                    count_next = count_reg + 16'd1;
                                end
                                spam_total_next = spam_total_reg + 32'd1;
                            end
                            b_spam_next = spam;
                            pos_next    = '0;
                            walk_next   = '0;
                        end
                    end
                end
                asrm_pkg::CMD_TICK:
                begin
                    if (running_reg)
                    begin
                        if (alert_left_reg != 16'd0)
                        begin
                            alert_left_next = alert_left_reg - 16'd1;
                        end
                        phase_next = phase_inc;
                        if (phase_inc >= second_len_reg)
                        begin
                            // interval close
                            phase_next       = 16'd0;
                            ram_we           = 1'b1;
                            slot_next        = (slot_reg == HIST_AW'(HISTORY_DEPTH - 1)) ?
                                               '0 : slot_reg + HIST_AW'(1);
                            if (fill_reg != FILL_W'(HISTORY_DEPTH))
                            begin
                                fill_next = fill_reg + FILL_W'(1);
                            end
                            last_rate_next   = count_reg;
                            total_snap_next  = spam_total_reg;
                            vendor_snap_next = vendor_live_reg;
                            if (count_reg > peak_reg)
                            begin
                                peak_next = count_reg;
                            end
                            if (count_reg >= threshold_reg)
                            begin
                                alert_left_next = hold_reg;
                            end
                            count_next = 16'd0;
                        end
                        if (ms_reg == 10'(asrm_pkg::MS_PER_SECOND - 1))
                        begin
                            ms_next   = 10'd0;
                            secs_next = secs_reg + 32'd1;
                        end
                        else
                        begin
                            ms_next = ms_reg + 10'd1;
                        end
                    end
                end
                asrm_pkg::CMD_RESTART:
                begin
                    pos_next        = '0;
                    walk_next       = '0;
                    count_next      = 16'd0;
                    spam_total_next = 32'd0;
                    for (int i = 0; i < asrm_pkg::VENDORS; i++)
                    begin
                        vendor_live_next[i] = 16'd0;
                        vendor_snap_next[i] = 16'd0;
                    end
                    total_snap_next = 32'd0;
                    last_rate_next  = 16'd0;
                    peak_next       = 16'd0;
                    slot_next       = '0;
                    fill_next       = '0;
                    phase_next      = 16'd0;
                    alert_left_next = 16'd0;
                    ms_next         = 10'd0;
                    secs_next       = 32'd0;
                    running_next    = 1'b1;
                end
                asrm_pkg::CMD_PAUSE:
                begin
                    if (running_reg)
                    begin
                        running_next = 1'b0;
                        pos_next     = '0;
                        walk_next    = '0;
                    end
                end
                asrm_pkg::CMD_RESUME:
                begin
                    if (!running_reg)
                    begin
                        running_next = 1'b1;
                        phase_next   = 16'd0;
                    end
                end
                asrm_pkg::CMD_READ:
                begin
                    ram_re         = idx_ok;
                    b_hist_ok_next = idx_ok && entry_valid;
                end
                default:
                begin
                end
            endcase
        end
    end

    // result beat from post-update state plus ram read data
    always_comb
    begin
        push_beat.rate            = last_rate_reg;
        push_beat.total           = total_snap_reg;
        push_beat.peak            = peak_reg;
        push_beat.count_cid_004c  = vendor_snap_reg[asrm_pkg::SLOT_004C];
        push_beat.count_cid_0006  = vendor_snap_reg[asrm_pkg::SLOT_0006];
        push_beat.count_cid_0075  = vendor_snap_reg[asrm_pkg::SLOT_0075];
        push_beat.count_uuid_fe2c = vendor_snap_reg[asrm_pkg::SLOT_FE2C];
        push_beat.alert           = alert_left_reg != 16'd0;
        push_beat.uptime_seconds  = secs_reg;
        push_beat.history_value   = b_hist_ok_reg ? ram_rdata : 16'd0;
        push_beat.advert_was_spam = b_spam_reg;
    end

    assign push      = b_valid_reg;
    assign out_valid = fifo_count_reg != 2'd0;
    assign out_data  = fifo_reg[fifo_rd_reg];
    assign pop       = out_valid && !out_stall;
    assign occupancy = 3'(fifo_count_reg) + 3'(b_valid_reg) - 3'(pop);
    assign in_stall  = occupancy >= 3'd2;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg  <= asrm_pkg::ALERT_THRESHOLD_RESET;
            second_len_reg <= asrm_pkg::SECOND_LENGTH_MS_RESET;
            hold_reg       <= asrm_pkg::ALERT_HOLD_MS_RESET;
            pos_reg        <= '0;
            walk_reg       <= '0;
            count_reg      <= 16'd0;
            spam_total_reg <= 32'd0;
            for (int i = 0; i < asrm_pkg::VENDORS; i++)
            begin
                vendor_live_reg[i] <= 16'd0;
                vendor_snap_reg[i] <= 16'd0;
            end
            total_snap_reg <= 32'd0;
            last_rate_reg  <= 16'd0;
            peak_reg       <= 16'd0;
            slot_reg       <= '0;
            fill_reg       <= '0;
            phase_reg      <= 16'd0;
            alert_left_reg <= 16'd0;
            ms_reg         <= 10'd0;
            secs_reg       <= 32'd0;
            running_reg    <= 1'b1;
            b_valid_reg    <= 1'b0;
            b_spam_reg     <= 1'b0;
            b_hist_ok_reg  <= 1'b0;
            fifo_wr_reg    <= 1'b0;
            fifo_rd_reg    <= 1'b0;
            fifo_count_reg <= 2'd0;
        end
        else
        begin
            if (cfg_write)
            begin
                case (cfg_index)
                    asrm_pkg::REG_ALERT_THRESHOLD:  threshold_reg  <= cfg_data;
                    asrm_pkg::REG_SECOND_LENGTH_MS: second_len_reg <= cfg_data;
                    asrm_pkg::REG_ALERT_HOLD_MS:    hold_reg       <= cfg_data;
                    default:
                    begin
                    end
                endcase
            end
            pos_reg         <= pos_next;
            walk_reg        <= walk_next;
            count_reg       <= count_next;
            spam_total_reg  <= spam_total_next;
            vendor_live_reg <= vendor_live_next;
            vendor_snap_reg <= vendor_snap_next;
            total_snap_reg  <= total_snap_next;
            last_rate_reg   <= last_rate_next;
            peak_reg        <= peak_next;
            slot_reg        <= slot_next;
            fill_reg        <= fill_next;
            phase_reg       <= phase_next;
            alert_left_reg  <= alert_left_next;
            ms_reg          <= ms_next;
            secs_reg        <= secs_next;
            running_reg     <= running_next;
            b_valid_reg     <= accept;
            b_spam_reg      <= b_spam_next;
            b_hist_ok_reg   <= b_hist_ok_next;
            if (push)
            begin
                fifo_wr_reg <= ~fifo_wr_reg;
            end
            if (pop)
            begin
                fifo_rd_reg <= ~fifo_rd_reg;
            end
            fifo_count_reg <= fifo_count_reg + 2'(push) - 2'(pop);
        end
    end

    // queue entries carry payload only
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            fifo_reg[fifo_wr_reg] <= push_beat;
        end
    end

    a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fifo_count_reg != 2'd3)
        else $error("output queue overflow");

    a_read_stage_room: assert property (@(posedge clk) disable iff (!rst_n)
        b_valid_reg |-> fifo_count_reg != 2'd2)
        else $error("beat in read stage with full output queue");

    a_ram_single_access: assert property (@(posedge clk) disable iff (!rst_n)
        !(ram_we && ram_re))
        else $error("history write and read in one cycle");

    a_walk_limit: assert property (@(posedge clk) disable iff (!rst_n)
        (32'(pos_reg) >= ADV_BYTES) |-> walk_reg.ended)
        else $error("byte limit reached without ending the walk");

endmodule

// ----- verif/adv_spam_rate_monitor_checker.sv -----
// ----------------------------------------------------------------------------
// adv_spam_rate_monitor_checker
// watches the input, output and register ports of the spam rate monitor,
// keeps its own copy of the advert walk, counters, history ring and alert
// hold, predicts one result beat per accepted input beat and compares every
// output beat field by field against the oldest prediction
// ----------------------------------------------------------------------------
module adv_spam_rate_monitor_checker
    import asrm_pkg::*;
#(
    parameter int HISTORY_DEPTH = 64,
    parameter int ADV_BYTES     = 31
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_stall,
    input  in_t         in_data,
    input  logic        out_valid,
    input  logic        out_stall,
    input  out_t        out_data,
    input  logic        cfg_write,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data,
    output int          failures,
    output int          pending,
    output int          spam_flagged,
    output int          closes
);
    timeunit 1ns;
    timeprecision 1ps;

    logic [15:0] thr_q, len_q, hold_q;

    int          walk_pos;
    int          walk_off;
    logic [7:0]  walk_left;
    logic [7:0]  walk_type;
    logic        walk_done;
    logic        mk_found;
    logic [15:0] mk_id;
    logic        sv_found;
    logic [15:0] sv_uuid;

    logic [15:0] spam_cnt;
    logic [31:0] spam_sum;
    logic [15:0] vend_live [VENDORS];
    logic [15:0] vend_snap [VENDORS];
    logic [31:0] sum_snap;
    logic [15:0] rate_q;
    logic [15:0] peak_q;
    logic [15:0] hist_ring [HISTORY_DEPTH];
    int          hist_slot;
    logic [15:0] phase_q;
    logic [15:0] alert_q;
    int          ms_q;
    logic [31:0] secs_q;
    logic        run_q;

    out_t        expected_q [$];
    int          n_fail;
    int          n_out;
    int          n_flagged;
    int          n_closed;

    function automatic void clear_walk();
        walk_pos  = 0;
        walk_off  = 0;
        walk_left = '0;
        walk_type = '0;
        walk_done = 1'b0;
        mk_found  = 1'b0;
        mk_id     = '0;
        sv_found  = 1'b0;
        sv_uuid   = '0;
    endfunction

    function automatic void clear_monitor();
        clear_walk();
        spam_cnt = '0;
        spam_sum = '0;
        sum_snap = '0;
        for (int i = 0; i < VENDORS; i++)
        begin
            vend_live[i] = '0;
            vend_snap[i] = '0;
        end
        rate_q = '0;
        peak_q = '0;
        for (int i = 0; i < HISTORY_DEPTH; i++)
            hist_ring[i] = '0;
        hist_slot = 0;
        phase_q   = '0;
        alert_q   = '0;
        ms_q      = 0;
        secs_q    = '0;
        run_q     = 1'b1;
    endfunction

    function automatic out_t advance_monitor(input in_t beat);
        out_t        res;
        logic [15:0] hist_word;
        logic        flagged;
        logic [7:0]  b;
        hist_word = '0;
        flagged   = 1'b0;
        b         = beat.data_byte;
        case (beat.cmd)
            CMD_BYTE:
            begin
                if (run_q)
                begin
                    if (!walk_done && walk_pos < ADV_BYTES)
                    begin
                        walk_pos++;
                        if (walk_left == 0)
                        begin
                            if (b == 0)
                                walk_done = 1'b1;
                            else
                            begin
                                walk_left = b;
                                walk_off  = 0;
                            end
                        end
                        else
                        begin
                            if (walk_off == 0)
                                walk_type = b;
                            else if (walk_off == 1)
                            begin
                                if (walk_type == TYPE_MAKER && !mk_found)
                                    mk_id = {8'h00, b};
                                if (walk_type == TYPE_SERVICE && !sv_found)
                                    sv_uuid = {8'h00, b};
                            end
                            else if (walk_off == 2)
                            begin
                                if (walk_type == TYPE_MAKER && !mk_found)
                                begin
                                    mk_id[15:8] = b;
                                    mk_found    = 1'b1;
                                end
                                if (walk_type == TYPE_SERVICE && !sv_found)
                                begin
                                    sv_uuid[15:8] = b;
                                    sv_found      = 1'b1;
                                end
                            end
                            if (walk_off < 255)
                                walk_off++;
                            walk_left = walk_left - 8'd1;
                        end
                        if (walk_pos >= ADV_BYTES)
                            walk_done = 1'b1;
                    end
                    if (beat.last_byte)
                    begin
                        if (mk_found)
                        begin
                            if (mk_id == CID_004C)
                            begin
                                vend_live[SLOT_004C] = vend_live[SLOT_004C] + 16'd1;
                                flagged = 1'b1;
                            end
                            else if (mk_id == CID_0006)
                            begin
                                vend_live[SLOT_0006] = vend_live[SLOT_0006] + 16'd1;
                                flagged = 1'b1;
                            end
                            else if (mk_id == CID_0075)
                            begin
                                vend_live[SLOT_0075] = vend_live[SLOT_0075] + 16'd1;
                                flagged = 1'b1;
                            end
                        end
                        if (sv_found && sv_uuid == UUID_FE2C)
                        begin
                            vend_live[SLOT_FE2C] = vend_live[SLOT_FE2C] + 16'd1;
                            flagged = 1'b1;
                        end
                        if (flagged)
                        begin
                            if (spam_cnt != 16'hFFFF)
                                spam_cnt = spam_cnt + 16'd1;
                            spam_sum = spam_sum + 32'd1;
                            n_flagged++;
                        end
                        clear_walk();
                    end
                end
            end
            CMD_TICK:
            begin
                if (run_q)
                begin
                    if (alert_q != 0)
                        alert_q = alert_q - 16'd1;
                    phase_q = phase_q + 16'd1;
                    // interval close
                    if (phase_q >= len_q)
                    begin
                        phase_q              = '0;
                        hist_ring[hist_slot] = spam_cnt;
                        hist_slot            = (hist_slot + 1) % HISTORY_DEPTH;
                        rate_q               = spam_cnt;
                        sum_snap             = spam_sum;
                        vend_snap            = vend_live;
                        if (spam_cnt > peak_q)
                            peak_q = spam_cnt;
                        if (spam_cnt >= thr_q)
                            alert_q = hold_q;
                        spam_cnt = '0;
                        n_closed++;
                    end
                    ms_q++;
                    if (ms_q >= MS_PER_SECOND)
                    begin
                        ms_q   = 0;
                        secs_q = secs_q + 32'd1;
                    end
                end
            end
            CMD_RESTART:
                clear_monitor();
            CMD_PAUSE:
            begin
                if (run_q)
                begin
                    run_q = 1'b0;
                    clear_walk();
                end
            end
            CMD_RESUME:
            begin
                if (!run_q)
                begin
                    run_q   = 1'b1;
                    phase_q = '0;
                end
            end
            CMD_READ:
            begin
                if (beat.history_index < HISTORY_DEPTH)
                    hist_word = hist_ring[(hist_slot + beat.history_index) % HISTORY_DEPTH];
            end
            default:
                ;
        endcase
        res.rate            = rate_q;
        res.total           = sum_snap;
        res.peak            = peak_q;
        res.count_cid_004c  = vend_snap[SLOT_004C];
        res.count_cid_0006  = vend_snap[SLOT_0006];
        res.count_cid_0075  = vend_snap[SLOT_0075];
        res.count_uuid_fe2c = vend_snap[SLOT_FE2C];
        res.alert           = (alert_q != 0);
        res.uptime_seconds  = secs_q;
        res.history_value   = hist_word;
        res.advert_was_spam = flagged;
        return res;
    endfunction

    task automatic check_field(input string field, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want)
        begin
            n_fail++;
            if (n_fail <= 10)
                $display("result %0d %s: expected %0h, got %0h", n_out, field, want, got);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        out_t want;
        if (!rst_n)
        begin
            thr_q  = ALERT_THRESHOLD_RESET;
            len_q  = SECOND_LENGTH_MS_RESET;
            hold_q = ALERT_HOLD_MS_RESET;
            clear_monitor();
            expected_q.delete();
            n_fail    = 0;
            n_out     = 0;
            n_flagged = 0;
            n_closed  = 0;
            failures     <= 0;
            pending      <= 0;
            spam_flagged <= 0;
            closes       <= 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_q.size() == 0)
                begin
                    n_fail++;
                    if (n_fail <= 10)
                        $display("result %0d arrived with nothing expected", n_out);
                end
                else
                begin
                    want = expected_q.pop_front();
                    check_field("rate", want.rate, out_data.rate);
                    check_field("total", want.total, out_data.total);
                    check_field("peak", want.peak, out_data.peak);
                    check_field("count_cid_004c", want.count_cid_004c,
                                out_data.count_cid_004c);
                    check_field("count_cid_0006", want.count_cid_0006,
                                out_data.count_cid_0006);
                    check_field("count_cid_0075", want.count_cid_0075,
                                out_data.count_cid_0075);
                    check_field("count_uuid_fe2c", want.count_uuid_fe2c,
                                out_data.count_uuid_fe2c);
                    check_field("alert", want.alert, out_data.alert);
                    check_field("uptime_seconds", want.uptime_seconds,
                                out_data.uptime_seconds);
                    check_field("history_value", want.history_value,
                                out_data.history_value);
                    check_field("advert_was_spam", want.advert_was_spam,
                                out_data.advert_was_spam);
                end
                n_out++;
            end
            if (cfg_write)
            begin
                case (cfg_index)
                    REG_ALERT_THRESHOLD:  thr_q  = cfg_data;
                    REG_SECOND_LENGTH_MS: len_q  = cfg_data;
                    REG_ALERT_HOLD_MS:    hold_q = cfg_data;
                    default:              ;
                endcase
            end
            if (in_valid && !in_stall)
                expected_q.push_back(advance_monitor(in_data));
            failures     <= n_fail;
            pending      <= expected_q.size();
            spam_flagged <= n_flagged;
            closes       <= n_closed;
        end
    end

endmodule

// ----- verif/adv_spam_rate_monitor_tb.sv -----
// ----------------------------------------------------------------------------
// adv_spam_rate_monitor_tb
// drives advert bytes, ticks and control commands into the spam rate monitor
// under random gaps and output stalls, sweeps several register settings and
// reports the verdict from the checker's failure count
// ----------------------------------------------------------------------------
module adv_spam_rate_monitor_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import asrm_pkg::*;

    localparam int         HISTORY_DEPTH   = 64;
    localparam int         ADV_BYTES       = 31;
    localparam logic [2:0] CMD_SPARE_6     = 3'd6;
    localparam logic [2:0] CMD_SPARE_7     = 3'd7;
    localparam int         HOLD_OFF_CYCLES = 120;
    localparam int         PHASE_BEATS     = 60;
    localparam int         BURST_TICKS     = 150;

    logic        clk;
    logic        rst_n     = 1'b0;
    logic        in_valid  = 1'b0;
    logic        in_stall;
    in_t         in_data   = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    out_t        out_data;
    logic        cfg_write = 1'b0;
    logic [1:0]  cfg_index = '0;
    logic [15:0] cfg_data  = '0;

    int          failures;
    int          pending;
    int          spam_flagged;
    int          closes;
    int          beats_sent    = 0;
    bit          no_gaps       = 1'b0;
    bit          hold_off_req  = 1'b0;
    bit          holding       = 1'b0;
    logic [7:0]  advert_q [$];

    adv_spam_rate_monitor #(
        .HISTORY_DEPTH(HISTORY_DEPTH),
        .ADV_BYTES    (ADV_BYTES)
    ) i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .in_data  (in_data),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .out_data (out_data),
        .cfg_write(cfg_write),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data)
    );

    adv_spam_rate_monitor_checker #(
        .HISTORY_DEPTH(HISTORY_DEPTH),
        .ADV_BYTES    (ADV_BYTES)
    ) i_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .in_data     (in_data),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .out_data    (out_data),
        .cfg_write   (cfg_write),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .failures    (failures),
        .pending     (pending),
        .spam_flagged(spam_flagged),
        .closes      (closes)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_gaps || r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic in_t make_beat(input logic [2:0] cmd, input logic [7:0] b,
                                      input logic last, input logic [5:0] idx);
        in_t beat;
        beat.cmd           = cmd;
        beat.data_byte     = b;
        beat.last_byte     = last;
        beat.history_index = idx;
        return beat;
    endfunction

    task automatic send_beat(input in_t beat);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= beat;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        beats_sent++;
    endtask

    task automatic send_cmd(input logic [2:0] cmd);
        send_beat(make_beat(cmd, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                            6'($urandom_range(0, 63))));
    endtask

    task automatic send_side_cmd();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            send_cmd(CMD_TICK);
        else if (r < 85)
            send_cmd(CMD_READ);
        else if (r < 88)
            send_cmd(CMD_PAUSE);
        else
            send_cmd(CMD_RESUME);
    endtask

    task automatic send_advert(input bit interject);
        for (int i = 0; i < advert_q.size(); i++)
        begin
            if (interject && $urandom_range(0, 29) == 0)
                send_side_cmd();
            send_beat(make_beat(CMD_BYTE, advert_q[i], i == advert_q.size() - 1,
                                6'($urandom_range(0, 63))));
        end
    endtask

    // random structures, partly vendor hits, with zero length ends,
    // short structures, overlong adverts, raw noise and cut tails
    task automatic make_advert();
        int          target;
        int          kind;
        int          dlen;
        logic [7:0]  stype;
        logic [15:0] id;
        advert_q.delete();
        target = ($urandom_range(0, 9) == 0) ? $urandom_range(ADV_BYTES + 1, ADV_BYTES + 9)
                                             : $urandom_range(3, 20);
        if ($urandom_range(0, 19) == 0)
        begin
            repeat (target) advert_q.push_back(8'($urandom_range(0, 255)));
            return;
        end
        while (advert_q.size() < target)
        begin
            kind  = $urandom_range(0, 11);
            id    = 16'($urandom_range(0, 65535));
            dlen  = $urandom_range(2, 5);
            stype = 8'($urandom_range(0, 255));
            if (kind == 0)
            begin
                advert_q.push_back(8'h00);
                repeat ($urandom_range(0, 3)) advert_q.push_back(8'($urandom_range(0, 255)));
                break;
            end
            else if (kind <= 5)
            begin
                stype = TYPE_MAKER;
                case (kind)
                    1:       id = CID_004C;
                    2:       id = CID_0006;
                    3:       id = CID_0075;
                    default: ;
                endcase
            end
            else if (kind <= 8)
            begin
                stype = TYPE_SERVICE;
                if (kind != 8)
                    id = UUID_FE2C;
            end
            else if (kind == 9)
            begin
                stype = $urandom_range(0, 1) ? TYPE_MAKER : TYPE_SERVICE;
                id    = (stype == TYPE_MAKER) ? CID_004C : UUID_FE2C;
                dlen  = $urandom_range(0, 1);
            end
            else
                dlen = $urandom_range(0, 4);
            advert_q.push_back(8'(dlen + 1));
            advert_q.push_back(stype);
            for (int j = 0; j < dlen; j++)
                advert_q.push_back(j == 0 ? id[7:0] : j == 1 ? id[15:8]
                                                    : 8'($urandom_range(0, 255)));
        end
        if ($urandom_range(0, 9) == 0 && advert_q.size() > 2)
            void'(advert_q.pop_back());
    endtask

    task automatic run_random(input int beats);
        int start;
        int r;
        start = beats_sent;
        while (beats_sent - start < beats)
        begin
            r = $urandom_range(0, 99);
            if (r < 55)
            begin
                make_advert();
                send_advert(1'b1);
            end
            else if (r < 93)
                send_side_cmd();
            else if (r < 95)
                send_cmd(CMD_RESTART);
            else if (r < 97)
                send_cmd(r[0] ? CMD_SPARE_6 : CMD_SPARE_7);
            else
                send_beat(make_beat(CMD_BYTE, 8'($urandom_range(0, 255)),
                                    1'($urandom_range(0, 1)), 6'($urandom_range(0, 63))));
        end
    endtask

    task automatic write_regs(input logic [15:0] thr, input logic [15:0] len,
                              input logic [15:0] hold);
        cfg_write <= 1'b1;
        cfg_index <= REG_ALERT_THRESHOLD;
        cfg_data  <= thr;
        @(posedge clk);
        cfg_index <= REG_SECOND_LENGTH_MS;
        cfg_data  <= len;
        @(posedge clk);
        cfg_index <= REG_ALERT_HOLD_MS;
        cfg_data  <= hold;
        @(posedge clk);
        cfg_write <= 1'b0;
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (6) @(posedge clk);
    endtask

    // output side: random stalls, calm runs, and one long hold-off on request
    initial
    begin : receiver
        int n;
        @(posedge rst_n);
        @(posedge clk);
        forever
        begin
            if (hold_off_req)
            begin
                hold_off_req = 1'b0;
                holding      = 1'b1;
                out_stall <= 1'b1;
                repeat (HOLD_OFF_CYCLES) @(posedge clk);
                holding = 1'b0;
            end
            else
            begin
                n = pick_gap();
                if (n > 0)
                begin
                    out_stall <= 1'b1;
                    repeat (n) @(posedge clk);
                end
            end
            out_stall <= 1'b0;
            n = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 5);
            repeat (n) @(posedge clk);
        end
    end

    initial
    begin : stimulus
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed
        write_regs(16'd1, 16'd3, 16'd2);
        send_beat(make_beat(CMD_READ, 8'hFF, 1'b1, 6'd0));
        advert_q = '{8'h03, TYPE_MAKER, CID_0075[7:0], CID_0075[15:8]};
        send_advert(1'b0);
        advert_q = '{8'h02, TYPE_MAKER, CID_004C[7:0],
                     8'h03, TYPE_SERVICE, UUID_FE2C[7:0], UUID_FE2C[15:8]};
        send_advert(1'b0);
        advert_q = '{8'h00, 8'hFF};
        send_advert(1'b0);
        repeat (3) send_cmd(CMD_TICK);
        send_cmd(CMD_PAUSE);
        send_beat(make_beat(CMD_BYTE, 8'h03, 1'b1, 6'd0));
        send_cmd(CMD_TICK);
        send_cmd(CMD_PAUSE);
        send_cmd(CMD_RESUME);
        send_cmd(CMD_RESUME);
        send_cmd(CMD_SPARE_6);
        send_cmd(CMD_SPARE_7);
        send_beat(make_beat(CMD_READ, 8'h00, 1'b0, 6'd63));
        send_cmd(CMD_RESTART);
        wait_idle();

        // output hold-off while the input keeps pushing
        write_regs(16'd2, 16'd8, 16'd5);
        hold_off_req = 1'b1;
        while (!holding) @(posedge clk);
        no_gaps = 1'b1;
        run_random(40);
        no_gaps = 1'b0;
        run_random(PHASE_BEATS);
        wait_idle();

        write_regs(16'hFFFF, 16'hFFFF, 16'd1);
        run_random(PHASE_BEATS);
        wait_idle();

        // one close per tick over a couple of ring wraps
        write_regs(16'd0, 16'd1, 16'hFFFF);
        send_cmd(CMD_RESTART);
        for (int i = 0; i < BURST_TICKS; i++)
        begin
            if (i % 50 == 0)
            begin
                make_advert();
                send_advert(1'b0);
            end
            if (i % 37 == 0)
                send_cmd(CMD_READ);
            send_cmd(CMD_TICK);
        end
        wait_idle();

        write_regs(16'($urandom_range(0, 3)), 16'($urandom_range(2, 20)),
                   16'($urandom_range(1, 30)));
        run_random(PHASE_BEATS);
        wait_idle();

        $display("covered %0d input beats over five register settings, a long output",
                 beats_sent);
        $display("hold-off and a tick burst: %0d spam adverts, %0d intervals closed",
                 spam_flagged, closes);
        if (failures == 0 && pending == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    initial
    begin : watchdog
        #4_000_000;
        $display("simulation failed");
        $finish;
    end

endmodule
